### hdl/rci_pkg.sv
// ----------------------------------------------------------------------------
// rci_pkg
// Shared types and constants for the ray / infinite cylinder intersect block.
// ----------------------------------------------------------------------------
`default_nettype none

package rci_pkg;

  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;

  typedef enum logic [CfgAddrW-1:0] {
    REG_BASE_X,
    REG_BASE_Y,
    REG_BASE_Z,
    REG_AXIS_X,
    REG_AXIS_Y,
    REG_AXIS_Z,
    REG_RADIUS,
    REG_NEAR_LIMIT
  } rci_reg_t;

  // coefficient saturation limit, 2^62
  localparam logic signed [63:0] SatLim = 64'sh4000_0000_0000_0000;

  typedef struct packed {
    logic signed [31:0] base_x;
    logic signed [31:0] base_y;
    logic signed [31:0] base_z;
    logic signed [17:0] axis_x;
    logic signed [17:0] axis_y;
    logic signed [17:0] axis_z;
    logic [30:0]        radius;
    logic [30:0]        near_limit;
  } rci_cfg_t;

  // one classified ray waiting for the root stage
  typedef struct packed {
    logic [126:0]       disc;
    logic signed [63:0] a;
    logic signed [63:0] nb;
    logic [30:0]        best;
    logic               miss;
  } rci_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rci_qstat_t;

endpackage

`default_nettype wire

### hdl/rci_mul.sv
// ----------------------------------------------------------------------------
// rci_mul
// Pipelined signed multiplier, four 32x32 partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module rci_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [AW-1:0]        a,
  input  logic signed [BW-1:0]        b,
  output logic signed [AW+BW-1:0]     p
);

  logic signed [64:0] ax, bx;
  logic [63:0]        ma, mb;
  logic [63:0]        ma_r, mb_r;
  logic               neg_r [0:3];
  logic [63:0]        p00_r, p01_r, p10_r, p11_r;
  logic [63:0]        lo_r, hi_r;
  logic [64:0]        mid_r;
  logic [127:0]       sum_r;
  logic [127:0]       sgn;
  logic signed [AW+BW-1:0] p_r;

  always_comb begin
    ax = 65'(a);
    bx = 65'(b);
    ma = ax[64] ? 64'(-ax) : 64'(ax);
    mb = bx[64] ? 64'(-bx) : 64'(bx);
    sgn = neg_r[3] ? -sum_r : sum_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r     <= ma;
      mb_r     <= mb;
      neg_r[0] <= a[AW-1] ^ b[BW-1];
      p00_r    <= ma_r[31:0]  * mb_r[31:0];
      p01_r    <= ma_r[31:0]  * mb_r[63:32];
      p10_r    <= ma_r[63:32] * mb_r[31:0];
      p11_r    <= ma_r[63:32] * mb_r[63:32];
      neg_r[1] <= neg_r[0];
      mid_r    <= 65'(p01_r) + 65'(p10_r);
      lo_r     <= p00_r;
      hi_r     <= p11_r;
      neg_r[2] <= neg_r[1];
      sum_r    <= {hi_r, lo_r} + 128'({mid_r, 32'd0});
      neg_r[3] <= neg_r[2];
      p_r      <= signed'(sgn[AW+BW-1:0]);
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

### hdl/rci_front.sv
// ----------------------------------------------------------------------------
// rci_front
// Front pipeline: dot products, quadratic coefficients and discriminant.
// ----------------------------------------------------------------------------
`default_nettype none

module rci_front import rci_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] org_x,
  input  logic signed [31:0] org_y,
  input  logic signed [31:0] org_z,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] dir_z,
  input  logic [30:0]        best_dist,
  input  rci_cfg_t           cfg,
  output logic               out_valid,
  output rci_entry_t         out_entry
);

  localparam int NS = 20;

  logic [NS-1:0]      vld_r;
  logic [30:0]        best_r [0:NS-1];
  logic signed [31:0] d_r [0:2];
  logic signed [32:0] w_r [0:2];
  logic signed [31:0] org [0:2];
  logic signed [31:0] dir [0:2];
  logic signed [31:0] base [0:2];
  logic signed [17:0] axis [0:2];

  logic signed [63:0] dd_p [0:2];
  logic signed [64:0] dw_p [0:2];
  logic signed [65:0] ww_p [0:2];
  logic signed [49:0] da_p [0:2];
  logic signed [50:0] wa_p [0:2];
  logic signed [63:0] rr_p;

  logic signed [66:0] dd_r, dw_r;
  logic signed [67:0] ww_r;
  logic signed [51:0] da_r;
  logic signed [52:0] wa_r;
  logic signed [63:0] rr_r;

  logic signed [66:0] dd_dly_r [0:4];
  logic signed [66:0] dw_dly_r [0:4];
  logic signed [67:0] ww_dly_r [0:4];
  logic signed [63:0] rr_dly_r [0:4];

  logic signed [103:0] dada_p;
  logic signed [104:0] dawa_p;
  logic signed [105:0] wawa_p;

  logic signed [127:0] araw_r, braw_r, craw_r;
  logic signed [63:0]  a_r, b_r, c_r;
  logic signed [63:0]  a_dly_r [0:4];
  logic signed [63:0]  b_dly_r [0:4];
  logic signed [127:0] bb_p, ac_p, disc_c;

  logic [126:0]       disc_r;
  logic signed [63:0] a19_r, nb19_r;
  logic               miss_r;

  function automatic logic signed [63:0] sat_shift(input logic signed [127:0] v);
    logic signed [127:0] s;
    s = v >>> (3 * FRAC_BITS);
    if (s > 128'(SatLim)) begin
      return SatLim;
    end else if (s < -128'(SatLim)) begin
      return -SatLim;
    end else begin
      return s[63:0];
    end
  endfunction

  always_comb begin
    org[0]  = org_x;      org[1]  = org_y;      org[2]  = org_z;
    dir[0]  = dir_x;      dir[1]  = dir_y;      dir[2]  = dir_z;
    base[0] = cfg.base_x; base[1] = cfg.base_y; base[2] = cfg.base_z;
    axis[0] = cfg.axis_x; axis[1] = cfg.axis_y; axis[2] = cfg.axis_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  // stage 0: direction and origin relative to the base point
  always_ff @(posedge clk) begin
    if (en) begin
      best_r[0] <= best_dist;
      for (int k = 1; k < NS; k++) best_r[k] <= best_r[k-1];
      for (int i = 0; i < 3; i++) begin
        d_r[i] <= dir[i];
        w_r[i] <= 33'(org[i]) - 33'(base[i]);
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_dot
    rci_mul #(.AW(32), .BW(32)) u_dd (
      .clk(clk), .en(en), .a(d_r[i]), .b(d_r[i]), .p(dd_p[i]));
    rci_mul #(.AW(32), .BW(33)) u_dw (
      .clk(clk), .en(en), .a(d_r[i]), .b(w_r[i]), .p(dw_p[i]));
    rci_mul #(.AW(33), .BW(33)) u_ww (
      .clk(clk), .en(en), .a(w_r[i]), .b(w_r[i]), .p(ww_p[i]));
    rci_mul #(.AW(32), .BW(18)) u_da (
      .clk(clk), .en(en), .a(d_r[i]), .b(axis[i]), .p(da_p[i]));
    rci_mul #(.AW(33), .BW(18)) u_wa (
      .clk(clk), .en(en), .a(w_r[i]), .b(axis[i]), .p(wa_p[i]));
  end

  rci_mul #(.AW(32), .BW(32)) u_rr (
    .clk(clk), .en(en), .a(signed'({1'b0, cfg.radius})),
    .b(signed'({1'b0, cfg.radius})), .p(rr_p));

  // stage 6: sums over x, y, z
  always_ff @(posedge clk) begin
    if (en) begin
      dd_r <= 67'(dd_p[0]) + 67'(dd_p[1]) + 67'(dd_p[2]);
      dw_r <= 67'(dw_p[0]) + 67'(dw_p[1]) + 67'(dw_p[2]);
      ww_r <= 68'(ww_p[0]) + 68'(ww_p[1]) + 68'(ww_p[2]);
      da_r <= 52'(da_p[0]) + 52'(da_p[1]) + 52'(da_p[2]);
      wa_r <= 53'(wa_p[0]) + 53'(wa_p[1]) + 53'(wa_p[2]);
      rr_r <= rr_p;
      dd_dly_r[0] <= dd_r;
      dw_dly_r[0] <= dw_r;
      ww_dly_r[0] <= ww_r;
      rr_dly_r[0] <= rr_r;
      for (int k = 1; k < 5; k++) begin
        dd_dly_r[k] <= dd_dly_r[k-1];
        dw_dly_r[k] <= dw_dly_r[k-1];
        ww_dly_r[k] <= ww_dly_r[k-1];
        rr_dly_r[k] <= rr_dly_r[k-1];
      end
    end
  end

  rci_mul #(.AW(52), .BW(52)) u_dada (
    .clk(clk), .en(en), .a(da_r), .b(da_r), .p(dada_p));
  rci_mul #(.AW(52), .BW(53)) u_dawa (
    .clk(clk), .en(en), .a(da_r), .b(wa_r), .p(dawa_p));
  rci_mul #(.AW(53), .BW(53)) u_wawa (
    .clk(clk), .en(en), .a(wa_r), .b(wa_r), .p(wawa_p));

  // stages 12 and 13: exact coefficients, then floor shift and saturate
  always_ff @(posedge clk) begin
    if (en) begin
      araw_r <= (128'(dd_dly_r[4]) <<< (2 * FRAC_BITS)) - 128'(dada_p);
      braw_r <= ((128'(dw_dly_r[4]) <<< (2 * FRAC_BITS)) - 128'(dawa_p)) <<< 1;
      craw_r <= (128'(ww_dly_r[4]) <<< (2 * FRAC_BITS)) - 128'(wawa_p)
                - (128'(rr_dly_r[4]) <<< (2 * FRAC_BITS));
      a_r <= sat_shift(araw_r);
      b_r <= sat_shift(braw_r);
      c_r <= sat_shift(craw_r);
      a_dly_r[0] <= a_r;
      b_dly_r[0] <= b_r;
      for (int k = 1; k < 5; k++) begin
        a_dly_r[k] <= a_dly_r[k-1];
        b_dly_r[k] <= b_dly_r[k-1];
      end
    end
  end

  rci_mul #(.AW(64), .BW(64)) u_bb (
    .clk(clk), .en(en), .a(b_r), .b(b_r), .p(bb_p));
  rci_mul #(.AW(64), .BW(64)) u_ac (
    .clk(clk), .en(en), .a(a_r), .b(c_r), .p(ac_p));

  assign disc_c = bb_p - (ac_p <<< 2);

  // stage 19: classify; parallel ray or negative discriminant is a miss
  always_ff @(posedge clk) begin
    if (en) begin
      disc_r <= disc_c[126:0];
      a19_r  <= a_dly_r[4];
      nb19_r <= -b_dly_r[4];
      miss_r <= disc_c[127] | (a_dly_r[4] == 64'sd0);
    end
  end

  assign out_valid      = vld_r[NS-1];
  assign out_entry.disc = disc_r;
  assign out_entry.a    = a19_r;
  assign out_entry.nb   = nb19_r;
  assign out_entry.best = best_r[NS-1];
  assign out_entry.miss = miss_r;

endmodule

`default_nettype wire

### hdl/rci_fifo.sv
// ----------------------------------------------------------------------------
// rci_fifo
// Short word queue between the front and back pipelines.
// ----------------------------------------------------------------------------
`default_nettype none

module rci_fifo import rci_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  rci_entry_t wdata,
  input  logic       pop,
  output rci_entry_t rdata,
  output rci_qstat_t stat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  rci_entry_t    mem_r [0:DEPTH-1];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= wdata;
  end

  // pointers wrap at DEPTH, so any depth of two or more works
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      if (pop)  rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign rdata      = mem_r[rptr_r];
  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

`default_nettype wire

### hdl/rci_back.sv
// ----------------------------------------------------------------------------
// rci_back
// Back pipeline: square root, two root divisions, root choice and hit test.
// ----------------------------------------------------------------------------
`default_nettype none

module rci_back import rci_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  rci_entry_t  q_entry,
  input  rci_qstat_t  qstat,
  output logic        pop,
  input  logic [30:0] near_limit,
  input  logic        out_ready,
  output logic        out_valid,
  output logic        out_hit,
  output logic [30:0] out_new_dist
);

  localparam int NB = 100;         // 1 load, 64 root, 1 prep, 1 scale, 31 div, 2 final
  localparam int NW = 66 + FRAC_BITS;
  localparam int CW = (NW > 95) ? NW : 95;

  logic [NB-1:0]      vld_r;
  logic               en;

  logic [127:0]       sq_op_r  [0:64];
  logic [127:0]       sq_res_r [0:64];
  logic signed [63:0] a_pl_r   [0:64];
  logic signed [63:0] nb_pl_r  [0:64];
  logic [30:0]        best_pl_r [0:98];
  logic               miss_pl_r [0:98];

  logic [65:0]        dm_r [0:1];
  logic               dneg_r [0:1];
  logic [63:0]        dv_r;

  logic [63:0]        rm_r   [0:1][0:31];
  logic [30:0]        nl_r   [0:1][0:31];
  logic [30:0]        q_r    [0:1][0:31];
  logic               ovf_r  [0:1][0:31];
  logic               neg_r  [0:1][0:31];
  logic [63:0]        dv_pl_r [0:31];

  logic signed [32:0] t_r [0:1];
  logic               hit_r;
  logic [30:0]        nd_r;

  logic signed [65:0] n0, n1;
  logic [63:0]        s, mag_a;
  logic [NW-1:0]      nsh [0:1];
  logic signed [32:0] near_s, best_s, sel;

  assign en  = !vld_r[NB-1] || out_ready;
  assign pop = en && !qstat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NB-2:0], !qstat.empty};
    end
  end

  // stage 0 load, side data carried along
  always_ff @(posedge clk) begin
    if (en) begin
      sq_op_r[0]    <= {1'b0, q_entry.disc};
      sq_res_r[0]   <= '0;
      a_pl_r[0]     <= q_entry.a;
      nb_pl_r[0]    <= q_entry.nb;
      best_pl_r[0]  <= q_entry.best;
      miss_pl_r[0]  <= q_entry.miss;
      for (int k = 1; k < 65; k++) begin
        a_pl_r[k]  <= a_pl_r[k-1];
        nb_pl_r[k] <= nb_pl_r[k-1];
      end
      for (int k = 1; k < 99; k++) begin
        best_pl_r[k] <= best_pl_r[k-1];
        miss_pl_r[k] <= miss_pl_r[k-1];
      end
    end
  end

  // one root bit per stage
  for (genvar j = 1; j <= 64; j++) begin : g_sq
    localparam logic [127:0] Bit = 128'(1) << (2 * (64 - j));
    logic [127:0] trial;
    assign trial = sq_res_r[j-1] + Bit;
    always_ff @(posedge clk) begin
      if (en) begin
        if (sq_op_r[j-1] >= trial) begin
          sq_op_r[j]  <= sq_op_r[j-1] - trial;
          sq_res_r[j] <= (sq_res_r[j-1] >> 1) + Bit;
        end else begin
          sq_op_r[j]  <= sq_op_r[j-1];
          sq_res_r[j] <= sq_res_r[j-1] >> 1;
        end
      end
    end
  end

  always_comb begin
    s     = sq_res_r[64][63:0];
    n0    = 66'(nb_pl_r[64]) + signed'({2'b00, s});
    n1    = 66'(nb_pl_r[64]) - signed'({2'b00, s});
    mag_a = a_pl_r[64][63] ? 64'(-a_pl_r[64]) : 64'(a_pl_r[64]);
    for (int k = 0; k < 2; k++) nsh[k] = NW'(dm_r[k]) << FRAC_BITS;
  end

  // stage 65: magnitudes, signs and divisor 2|a|; stage 66: range check
  always_ff @(posedge clk) begin
    if (en) begin
      dm_r[0]   <= n0[65] ? 66'(-n0) : 66'(n0);
      dm_r[1]   <= n1[65] ? 66'(-n1) : 66'(n1);
      dneg_r[0] <= n0[65] ^ a_pl_r[64][63];
      dneg_r[1] <= n1[65] ^ a_pl_r[64][63];
      dv_r      <= mag_a << 1;
      dv_pl_r[0] <= dv_r;
      for (int k = 1; k < 32; k++) dv_pl_r[k] <= dv_pl_r[k-1];
      for (int k = 0; k < 2; k++) begin
        // a quotient at or above 2^31 can never be a hit: clamp it there
        ovf_r[k][0] <= CW'(nsh[k]) >= CW'({dv_r, 31'd0});
        rm_r[k][0]  <= 64'(nsh[k] >> 31);
        nl_r[k][0]  <= nsh[k][30:0];
        q_r[k][0]   <= '0;
        neg_r[k][0] <= dneg_r[k];
      end
    end
  end

  for (genvar k = 0; k < 2; k++) begin : g_div
    for (genvar i = 1; i < 32; i++) begin : g_step
      logic [64:0] rem2;
      logic        ge;
      assign rem2 = {rm_r[k][i-1], nl_r[k][i-1][30]};
      assign ge   = rem2 >= {1'b0, dv_pl_r[i-1]};
      always_ff @(posedge clk) begin
        if (en) begin
          rm_r[k][i]  <= ge ? 64'(rem2 - {1'b0, dv_pl_r[i-1]}) : rem2[63:0];
          nl_r[k][i]  <= nl_r[k][i-1] << 1;
          q_r[k][i]   <= {q_r[k][i-1][29:0], ge};
          ovf_r[k][i] <= ovf_r[k][i-1];
          neg_r[k][i] <= neg_r[k][i-1];
        end
      end
    end
  end

  always_comb begin
    near_s = signed'({2'b00, near_limit});
    best_s = signed'({2'b00, best_pl_r[98]});
    sel    = (t_r[0] < t_r[1] && t_r[0] > near_s) ? t_r[0] : t_r[1];
  end

  // stage 98: signed roots; stage 99: root choice and result word
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        t_r[k] <= neg_r[k][31]
                  ? -signed'({1'b0, ovf_r[k][31] ? 32'h8000_0000 : {1'b0, q_r[k][31]}})
                  :  signed'({1'b0, ovf_r[k][31] ? 32'h8000_0000 : {1'b0, q_r[k][31]}});
      end
      hit_r <= !miss_pl_r[98] && sel > near_s && sel < best_s;
      nd_r  <= (!miss_pl_r[98] && sel > near_s && sel < best_s) ? sel[30:0]
                                                                : best_pl_r[98];
    end
  end

  assign out_valid    = vld_r[NB-1];
  assign out_hit      = hit_r;
  assign out_new_dist = nd_r;

endmodule

`default_nettype wire

### hdl/ray_cylinder_intersect.sv
// ----------------------------------------------------------------------------
// ray_cylinder_intersect
// Ray against infinite cylinder, Q16.16, one ray per clock while in_ready is high.
// ----------------------------------------------------------------------------
//  channel | ports                           | moves
//  --------+---------------------------------+-------------------------------
//  in      | in_valid / in_ready             | ray word: origin, dir, best
//  out     | out_valid / out_ready           | result word: hit, new_dist
//  cfg     | cfg_we, cfg_addr, cfg_wdata     | register write, no wait
//
//  One ray per clock while in_ready is high; a taken ray passes the
//  coefficient stages of the front pipeline, the queue and the root
//  pipeline, where 64 square-root stages and 31 divider stages set most
//  of its depth.
//  Reset (rst_n low, synchronous) empties both pipelines and the queue.
//  An output stall holds the back pipeline; the queue then fills and
//  in_ready drops once it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_cylinder_intersect import rci_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  in_org_x,
  input  logic signed [31:0]  in_org_y,
  input  logic signed [31:0]  in_org_z,
  input  logic signed [31:0]  in_dir_x,
  input  logic signed [31:0]  in_dir_y,
  input  logic signed [31:0]  in_dir_z,
  input  logic [30:0]         in_best_dist,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_hit,
  output logic [30:0]         out_new_dist,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  rci_cfg_t   cfg_r;
  rci_entry_t f_entry, q_head;
  rci_qstat_t qstat;
  logic       f_valid, en_f, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_x     <= '0;
      cfg_r.base_y     <= '0;
      cfg_r.base_z     <= '0;
      cfg_r.axis_x     <= '0;
      cfg_r.axis_y     <= 18'sd65536;
      cfg_r.axis_z     <= '0;
      cfg_r.radius     <= 31'd65536;
      cfg_r.near_limit <= 31'd7;
    end else if (cfg_we) begin
      case (rci_reg_t'(cfg_addr))
        REG_BASE_X:     cfg_r.base_x     <= cfg_wdata;
        REG_BASE_Y:     cfg_r.base_y     <= cfg_wdata;
        REG_BASE_Z:     cfg_r.base_z     <= cfg_wdata;
        REG_AXIS_X:     cfg_r.axis_x     <= cfg_wdata[17:0];
        REG_AXIS_Y:     cfg_r.axis_y     <= cfg_wdata[17:0];
        REG_AXIS_Z:     cfg_r.axis_z     <= cfg_wdata[17:0];
        REG_RADIUS:     cfg_r.radius     <= cfg_wdata[30:0];
        REG_NEAR_LIMIT: cfg_r.near_limit <= cfg_wdata[30:0];
        default:        cfg_r            <= cfg_r;
      endcase
    end
  end

  assign en_f     = !qstat.full;
  assign in_ready = en_f;

  rci_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en_f),
    .in_valid  (in_valid),
    .org_x     (in_org_x),
    .org_y     (in_org_y),
    .org_z     (in_org_z),
    .dir_x     (in_dir_x),
    .dir_y     (in_dir_y),
    .dir_z     (in_dir_z),
    .best_dist (in_best_dist),
    .cfg       (cfg_r),
    .out_valid (f_valid),
    .out_entry (f_entry)
  );

  rci_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (en_f && f_valid),
    .wdata (f_entry),
    .pop   (q_pop),
    .rdata (q_head),
    .stat  (qstat)
  );

  rci_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_entry      (q_head),
    .qstat        (qstat),
    .pop          (q_pop),
    .near_limit   (cfg_r.near_limit),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_hit      (out_hit),
    .out_new_dist (out_new_dist)
  );

endmodule

`default_nettype wire

### hdl/rci_checker.sv
// ----------------------------------------------------------------------------
// rci_checker
// Port-level checks on the intersect block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rci_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_hit,
  input logic [30:0] out_new_dist
);

  // a waiting result word must not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_new_dist))
    else $error("result word changed while stalled");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

  // a hit lies beyond the near limit, so never at zero
  a_hit_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_new_dist != 31'd0)
    else $error("hit at zero distance");

endmodule

bind ray_cylinder_intersect rci_checker u_rci_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_hit      (out_hit),
  .out_new_dist (out_new_dist)
);

`default_nettype wire
